### rtl/jmdf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the join match tracker.
// No dependencies; imported by every module of the block.
package jmdf_pkg;

  localparam int CmdW  = 2;
  localparam int ModeW = 4;

  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CmdW-1:0] CMD_PAIR  = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;

  localparam logic [ModeW-1:0] MODE_OTHER   = 4'd0;
  localparam logic [ModeW-1:0] MODE_LOUTER  = 4'd1;
  localparam logic [ModeW-1:0] MODE_LSEMI   = 4'd2;
  localparam logic [ModeW-1:0] MODE_LANTI   = 4'd3;
  localparam logic [ModeW-1:0] MODE_NAANTI  = 4'd4;
  localparam logic [ModeW-1:0] MODE_ROUTER  = 4'd5;
  localparam logic [ModeW-1:0] MODE_RSEMI   = 4'd6;
  localparam logic [ModeW-1:0] MODE_RANTI   = 4'd7;
  localparam logic [ModeW-1:0] MODE_FOUTER  = 4'd8;

  localparam logic CFG_JOIN_MODE   = 1'b0;
  localparam logic CFG_TABLE_EMPTY = 1'b1;

  typedef enum logic [2:0] {
    CNT_NONE,
    CNT_LOAD,
    CNT_DEC,
    CNT_ONE,
    CNT_ZERO
  } cnt_op_t;

  typedef struct packed {
    cnt_op_t cnt_op;
    logic    mark_set;
    logic    keep;
    logic    mark_out;
  } ctl_t;

endpackage

### rtl/jmdf_rules.sv
`timescale 1ns / 1ps
// Join-mode rules: decides keep, mark readback and state updates for one beat.
// Depends on jmdf_pkg.
module jmdf_rules
  import jmdf_pkg::*;
(
  input  logic [CmdW-1:0]  cmd,
  input  logic [ModeW-1:0] join_mode,
  input  logic             table_empty,
  input  logic             filter_in,
  input  logic             cnt_zero,
  input  logic             cnt_one,
  input  logic             mark,
  output ctl_t             ctl
);

  always_comb begin
    ctl = '{cnt_op: CNT_NONE, mark_set: 1'b0, keep: 1'b0, mark_out: 1'b0};
    case (cmd)
      CMD_LOAD: begin
        ctl.cnt_op = CNT_LOAD;
      end
      CMD_READ: begin
        ctl.mark_out = mark;
      end
      CMD_PAIR: begin
        if (table_empty) begin
          ctl.keep = (join_mode inside {MODE_LOUTER, MODE_LANTI, MODE_NAANTI, MODE_FOUTER})
                     ? 1'b1 : filter_in;
        end else begin
          case (join_mode)
            MODE_LOUTER: begin
              if (cnt_zero || cnt_one) begin
                ctl.keep = 1'b1;
              end else begin
                ctl.keep = filter_in;
                if (!filter_in) ctl.cnt_op = CNT_DEC;
              end
            end
            MODE_LSEMI: begin
              if (filter_in && cnt_zero) begin
                ctl.cnt_op = CNT_ONE;
                ctl.keep   = 1'b1;
              end
            end
            MODE_LANTI, MODE_NAANTI: begin
              if (cnt_zero) begin
                ctl.keep = 1'b1;
              end else if (cnt_one) begin
                ctl.cnt_op = CNT_ZERO;
                ctl.keep   = !filter_in;
              end else if (!filter_in) begin
                ctl.cnt_op = CNT_DEC;
              end
            end
            MODE_ROUTER, MODE_RANTI: begin
              ctl.keep     = filter_in;
              ctl.mark_set = filter_in;
            end
            MODE_RSEMI: begin
              if (filter_in && !mark) begin
                ctl.mark_set = 1'b1;
                ctl.keep     = 1'b1;
              end
            end
            MODE_FOUTER: begin
              if (cnt_zero) begin
                ctl.keep = 1'b1;
              end else begin
                ctl.mark_set = filter_in;
                if (cnt_one) begin
                  ctl.keep = 1'b1;
                end else begin
                  ctl.keep = filter_in;
                  if (!filter_in) ctl.cnt_op = CNT_DEC;
                end
              end
            end
            default: begin
              ctl.keep = filter_in;
            end
          endcase
        end
      end
      default: begin
        ctl.cnt_op = CNT_NONE;
      end
    endcase
  end

endmodule

### rtl/jmdf_count_store.sv
`timescale 1ns / 1ps
// Per-probe-row remaining-candidate counters: synchronous memory with
// read-modify-write and one-deep write forwarding. Depends on jmdf_pkg.
module jmdf_count_store
  import jmdf_pkg::*;
#(
  parameter int ROWS = 4096,
  parameter int BITS = 16,
  localparam int AW  = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  logic            wr_go,
  input  logic [AW-1:0]   wr_addr,
  input  cnt_op_t         op,
  input  logic [BITS-1:0] load_value,
  output logic            cnt_zero,
  output logic            cnt_one
);

  logic [BITS-1:0] mem [ROWS];
  logic [BITS-1:0] rd_data;
  logic            fwd_valid;
  logic [AW-1:0]   fwd_addr;
  logic [BITS-1:0] fwd_data;
  logic [BITS-1:0] cur;
  logic [BITS-1:0] wr_data;
  logic            wr_en;

  assign cur      = (fwd_valid && fwd_addr == wr_addr) ? fwd_data : rd_data;
  assign cnt_zero = (cur == '0);
  assign cnt_one  = (cur == BITS'(1));
  assign wr_en    = wr_go && (op != CNT_NONE);

  always_comb begin
    case (op)
      CNT_LOAD: wr_data = load_value;
      CNT_DEC:  wr_data = cur - BITS'(1);
      CNT_ONE:  wr_data = BITS'(1);
      default:  wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

endmodule

### rtl/jmdf_mark_store.sv
`timescale 1ns / 1ps
// Per-build-row matched marks: synchronous memory with a clearing sweep
// after reset and one-deep set forwarding. Depends on jmdf_pkg.
module jmdf_mark_store
  import jmdf_pkg::*;
#(
  parameter int ROWS = 65536,
  localparam int AW  = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          set_en,
  input  logic [AW-1:0] set_addr,
  output logic          mark,
  output logic          busy
);

  logic          mem [ROWS];
  logic          rd_data;
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [AW-1:0] clr_addr;
  logic          clr_last;

  assign mark     = rd_data || (fwd_valid && fwd_addr == set_addr);
  assign clr_last = (clr_addr == AW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (set_en) begin
      mem[set_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clr_addr  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_last) busy <= 1'b0;
      end
      if (set_en) fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (set_en) begin
      fwd_addr <= set_addr;
    end
  end

endmodule

### rtl/join_match_dedup_filter.sv
`timescale 1ns / 1ps
// Top level of the hash-join post-filter match tracker.
// Depends on jmdf_pkg, jmdf_rules, jmdf_count_store, jmdf_mark_store.
//
// Usage:
//   s_* carries command beats: s_tuser holds cmd (load probe counter,
//   filter candidate pair, read build mark); s_tdata holds the row indexes,
//   the filter bit and the counter value. m_* returns one result beat per
//   command beat, in order, with keep and mark_out in m_tdata.
//   cfg_we/cfg_index/cfg_data write join_mode (index 0) and table_empty
//   (index 1); write them only while no beats are in flight.
//   Pipeline: an accepted beat's memory reads are issued as it enters the
//   update stage (v1); the update and the output register load happen when
//   that stage advances. Throughput is one beat per cycle while the output
//   is not stalled and no clearing sweep runs, with one read-modify-write of
//   each memory per beat; back-to-back updates to the same row are forwarded.
//   Reset: counters are left undefined and must be loaded before use; the
//   build marks are cleared by a sweep over all BUILD_ROWS rows, during which
//   s_tready stays low.
//   Stall: with m_tready low and a result waiting, the pipeline holds and
//   s_tready drops. PROBE_ROWS and BUILD_ROWS are powers of two; row
//   indexes wrap modulo the store depth.
module join_match_dedup_filter
  import jmdf_pkg::*;
#(
  parameter int PROBE_ROWS = 4096,
  parameter int BUILD_ROWS = 65536,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // probe_row[11:0], build_row[27:12], filter_in[28],
                                 // count_value[44:29], zero fill
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // keep[0], mark_out[1], zero fill
);

  localparam int PAW = $clog2(PROBE_ROWS);
  localparam int BAW = $clog2(BUILD_ROWS);

  logic [ModeW-1:0] join_mode;
  logic             table_empty;

  logic [PAW-1:0]   in_probe;
  logic [BAW-1:0]   in_build;

  logic             advance;
  logic             v1;
  logic [CmdW-1:0]  cmd1;
  logic [PAW-1:0]   probe1;
  logic [BAW-1:0]   build1;
  logic             filter1;
  logic [COUNT_BITS-1:0] count1;

  logic             cnt_zero;
  logic             cnt_one;
  logic             mark;
  logic             clr_busy;
  ctl_t             ctl;

  logic             out_valid;
  logic             out_keep;
  logic             out_mark;

  assign in_probe = PAW'(s_tdata[11:0]);
  assign in_build = BAW'(s_tdata[27:12]);
  assign advance  = !out_valid || m_tready;
  assign s_tready = advance && !clr_busy;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_mark, out_keep};

  always_ff @(posedge clk) begin
    if (rst) begin
      join_mode   <= MODE_OTHER;
      table_empty <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_JOIN_MODE:   join_mode   <= cfg_data;
        CFG_TABLE_EMPTY: table_empty <= cfg_data[0];
        default:         join_mode   <= join_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= s_tvalid && s_tready;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd1     <= s_tuser;
      probe1   <= in_probe;
      build1   <= in_build;
      filter1  <= s_tdata[28];
      count1   <= COUNT_BITS'(s_tdata[44:29]);
      out_keep <= ctl.keep;
      out_mark <= ctl.mark_out;
    end
  end

  jmdf_count_store #(
    .ROWS (PROBE_ROWS),
    .BITS (COUNT_BITS)
  ) u_count (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (advance),
    .rd_addr    (in_probe),
    .wr_go      (advance && v1),
    .wr_addr    (probe1),
    .op         (ctl.cnt_op),
    .load_value (count1),
    .cnt_zero   (cnt_zero),
    .cnt_one    (cnt_one)
  );

  jmdf_mark_store #(
    .ROWS (BUILD_ROWS)
  ) u_mark (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (advance),
    .rd_addr  (in_build),
    .set_en   (advance && v1 && ctl.mark_set),
    .set_addr (build1),
    .mark     (mark),
    .busy     (clr_busy)
  );

  jmdf_rules u_rules (
    .cmd         (cmd1),
    .join_mode   (join_mode),
    .table_empty (table_empty),
    .filter_in   (filter1),
    .cnt_zero    (cnt_zero),
    .cnt_one     (cnt_one),
    .mark        (mark),
    .ctl         (ctl)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("beat accepted during mark clearing sweep");

  a_accept_enters_stage: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted beat lost before update stage");

  a_single_result_field: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_keep && out_mark))
    else $error("keep and mark_out both set in one result");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && !advance) |=> (v1 && $stable(probe1) && $stable(build1)))
    else $error("update stage changed while output stalled");

endmodule
